// File: rtl/sro_pkg.sv
package sro_pkg;

  // Field widths of the item and of the stored state.
  localparam int SEQ_W  = 16;
  localparam int KEY_W  = 17;
  localparam int LR_W   = 18;
  localparam int HDL_W  = 16;
  localparam int MISS_W = 16;
  localparam int STAT_W = 3;

  // Sequence numbers below this value count as wrapped once the last read passes it.
  localparam int WRAP_LOW = 1 << 14;

  // Operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_LATE     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_READ     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd5;

  // Per-cell load selects: shift up from the lower cell, take the new item,
  // or shift down from the upper cell.
  typedef struct packed {
    logic take_prev;
    logic take_new;
    logic take_next;
  } cell_ctl_t;

  // Per-cell compare result against the incoming key.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

  // Sort key of a sequence number. Adding 65536 to a value below WRAP_LOW
  // only sets bit 16, so the key is a concatenation.
  function automatic logic [KEY_W-1:0] key_of(input logic [SEQ_W-1:0] seq,
                                               input logic wrap);
    key_of = {wrap && (seq < SEQ_W'(WRAP_LOW)), seq};
  endfunction

endpackage

// File: rtl/sro_cell.sv
module sro_cell (
  input  logic                      clk,
  input  logic                      flag_load,
  input  logic [sro_pkg::KEY_W-1:0] in_key,
  input  logic                      wrap,
  input  logic                      valid,
  input  sro_pkg::cell_ctl_t        ctl,
  input  logic [sro_pkg::SEQ_W-1:0] prev_seq,
  input  logic [sro_pkg::HDL_W-1:0] prev_handle,
  input  logic [sro_pkg::SEQ_W-1:0] next_seq,
  input  logic [sro_pkg::HDL_W-1:0] next_handle,
  input  logic [sro_pkg::SEQ_W-1:0] new_seq,
  input  logic [sro_pkg::HDL_W-1:0] new_handle,
  output logic [sro_pkg::SEQ_W-1:0] seq,
  output logic [sro_pkg::HDL_W-1:0] handle,
  output sro_pkg::cell_flag_t       flag
);
  import sro_pkg::*;

  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [HDL_W-1:0] handle_r, handle_nxt;
  cell_flag_t       flag_r, flag_nxt;
  logic [KEY_W-1:0] cell_key;

  // Entry select: insert shifts up, read shifts down.
  always_comb begin
    seq_nxt    = seq_r;
    handle_nxt = handle_r;
    if (ctl.take_prev) begin
      seq_nxt    = prev_seq;
      handle_nxt = prev_handle;
    end else if (ctl.take_new) begin
      seq_nxt    = new_seq;
      handle_nxt = new_handle;
    end else if (ctl.take_next) begin
      seq_nxt    = next_seq;
      handle_nxt = next_handle;
    end
  end

  // Compare this cell's key, under the current wrap rule, with the incoming key.
  always_comb begin
    cell_key    = key_of(seq_r, wrap);
    flag_nxt.lt = valid && (cell_key < in_key);
    flag_nxt.eq = valid && (cell_key == in_key);
  end

  always_ff @(posedge clk) begin
    seq_r    <= seq_nxt;
    handle_r <= handle_nxt;
    if (flag_load) begin
      flag_r <= flag_nxt;
    end
  end

  assign seq    = seq_r;
  assign handle = handle_r;
  assign flag   = flag_r;

endmodule

// File: rtl/sro_scan.sv
module sro_scan #(
  parameter int DEPTH = 64
) (
  input  logic [DEPTH-1:0] le,
  output logic [DEPTH-1:0] incl
);
  import sro_pkg::*;

  localparam int LVL = $clog2(DEPTH);

  logic [LVL:0][DEPTH-1:0] lvl;

  // Parallel suffix OR: incl[i] is set when any cell at i or above matched.
  always_comb begin
    lvl[0] = le;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i + (1 << l) < DEPTH) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i + (1 << l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign incl = lvl[LVL];

endmodule

// File: rtl/sequence_reorder_buffer_top.sv
// Channel  | Direction | Ports
// ---------+-----------+---------------------------------------------------------------
// in       | input     | in_valid, in_ready, in_opcode, in_seq_num, in_packet_handle
// out      | output    | out_valid, out_ready, out_status, out_seq, out_handle,
//          |           | out_missing_count, out_occupancy
//
// Each item is handled in two steps: the accept cycle, when every cell compares
// its entry with the new key, and a commit cycle, when the match scan picks the
// slot and the cell row shifts. A new item is accepted only after the last commit.
// The result sits in an output register; while it waits, the next item can still
// be accepted, and only its commit waits for the output register to free up.
// Reset empties the buffer and sets the last read to minus one.
module sequence_reorder_buffer_top #(
  parameter  int DEPTH = 64,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [sro_pkg::SEQ_W-1:0]   in_seq_num,
  input  logic [sro_pkg::HDL_W-1:0]   in_packet_handle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sro_pkg::STAT_W-1:0]  out_status,
  output logic [sro_pkg::SEQ_W-1:0]   out_seq,
  output logic [sro_pkg::HDL_W-1:0]   out_handle,
  output logic [sro_pkg::MISS_W-1:0]  out_missing_count,
  output logic [CW-1:0]               out_occupancy
);
  import sro_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic                    state_r, state_nxt;
  logic                    op_r;
  logic [KEY_W-1:0]        key_r;
  logic [HDL_W-1:0]        hdl_r;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [LR_W-1:0]  last_r, last_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, res_status;
  logic [SEQ_W-1:0]        out_seq_r, res_seq;
  logic [HDL_W-1:0]        out_handle_r, res_handle;
  logic [MISS_W-1:0]       out_miss_r, res_miss;
  logic [CW-1:0]           out_occ_r;

  logic                    in_fire, commit, wrap;
  logic [KEY_W-1:0]        in_key, head_key;
  logic [LR_W-1:0]         miss_wide;
  logic                    dup, late, full, empty, do_ins, do_rd;
  logic [STAT_W-1:0]       app_status;

  logic [SEQ_W-1:0]        cell_seq    [DEPTH];
  logic [HDL_W-1:0]        cell_handle [DEPTH];
  cell_flag_t              cell_flag   [DEPTH];
  cell_ctl_t               cell_ctl    [DEPTH];
  logic [DEPTH-1:0]        valid_vec, le_vec, eq_vec, incl, hit, ins_prev, ins_new;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign commit   = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  // Wrap rule under the current last read, shared by every cell.
  assign wrap   = last_r > $signed(LR_W'(WRAP_LOW));
  assign in_key = key_of(in_seq_num, wrap);

  // Cell occupancy and the match vectors that feed the scan.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = CW'(i) < count_r;
      le_vec[i]    = cell_flag[i].lt | cell_flag[i].eq;
      eq_vec[i]    = cell_flag[i].eq;
    end
  end

  sro_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .le   (le_vec),
    .incl (incl)
  );

  // The hit is the highest matching cell; the item goes just above it.
  assign hit      = le_vec & ~(incl >> 1);
  assign ins_prev = ~(incl << 1) & ~{{(DEPTH-1){1'b0}}, 1'b1};
  assign ins_new  = (hit << 1) | {{(DEPTH-1){1'b0}}, ~incl[0]};

  // Append decision: duplicate, then late, then full.
  always_comb begin
    dup   = |(hit & eq_vec);
    late  = !incl[0] && !(last_r < $signed({1'b0, key_r}));
    full  = (count_r == CW'(DEPTH));
    empty = (count_r == '0);
    if (dup) begin
      app_status = STAT_DUP;
    end else if (late) begin
      app_status = STAT_LATE;
    end else if (full) begin
      app_status = STAT_FULL;
    end else begin
      app_status = STAT_INSERTED;
    end
    do_ins = commit && (op_r == OP_APPEND) && (app_status == STAT_INSERTED);
    do_rd  = commit && (op_r == OP_READ) && !empty;
  end

  // Load selects for the cell row.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].take_prev = do_ins && ins_prev[i];
      cell_ctl[i].take_new  = do_ins && ins_new[i];
      cell_ctl[i].take_next = do_rd && (i < DEPTH - 1);
    end
  end

  // Row of cells, each wired to its lower and upper neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [SEQ_W-1:0] p_seq, n_seq;
    logic [HDL_W-1:0] p_hdl, n_hdl;

    if (g == 0) begin : g_head
      assign p_seq = key_r[SEQ_W-1:0];
      assign p_hdl = hdl_r;
    end else begin : g_body
      assign p_seq = cell_seq[g-1];
      assign p_hdl = cell_handle[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign n_seq = cell_seq[g];
      assign n_hdl = cell_handle[g];
    end else begin : g_up
      assign n_seq = cell_seq[g+1];
      assign n_hdl = cell_handle[g+1];
    end

    sro_cell u_cell (
      .clk         (clk),
      .flag_load   (in_fire),
      .in_key      (in_key),
      .wrap        (wrap),
      .valid       (valid_vec[g]),
      .ctl         (cell_ctl[g]),
      .prev_seq    (p_seq),
      .prev_handle (p_hdl),
      .next_seq    (n_seq),
      .next_handle (n_hdl),
      .new_seq     (key_r[SEQ_W-1:0]),
      .new_handle  (hdl_r),
      .seq         (cell_seq[g]),
      .handle      (cell_handle[g]),
      .flag        (cell_flag[g])
    );
  end

  // Head entry and the count of skipped numbers for a read.
  assign head_key  = key_of(cell_seq[0], wrap);
  assign miss_wide = {1'b0, head_key} - LR_W'(last_r) - LR_W'(1);

  // Result fields, buffer count and last read.
  always_comb begin
    res_status = app_status;
    res_seq    = '0;
    res_handle = '0;
    res_miss   = '0;
    if (op_r == OP_READ) begin
      if (empty) begin
        res_status = STAT_EMPTY;
      end else begin
        res_status = STAT_READ;
        res_seq    = cell_seq[0];
        res_handle = cell_handle[0];
        res_miss   = miss_wide[MISS_W-1:0];
      end
    end
    count_nxt = count_r;
    last_nxt  = last_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end
    if (do_rd) begin
      count_nxt = count_r - CW'(1);
      last_nxt  = $signed({2'b00, cell_seq[0]});
    end
  end

  // Sequencing and output register handshake.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      state_nxt = S_COMMIT;
    end else if (commit) begin
      state_nxt = S_IDLE;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Accepted item and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_opcode;
      key_r <= in_key;
      hdl_r <= in_packet_handle;
    end
    if (commit) begin
      out_status_r <= res_status;
      out_seq_r    <= res_seq;
      out_handle_r <= res_handle;
      out_miss_r   <= res_miss;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_seq           = out_seq_r;
  assign out_handle        = out_handle_r;
  assign out_missing_count = out_miss_r;
  assign out_occupancy     = out_occ_r;

endmodule

// File: rtl/sro_checker.sv
module sro_checker #(
  parameter  int DEPTH = 64,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sro_pkg::STAT_W-1:0]  out_status,
  input logic [sro_pkg::SEQ_W-1:0]   out_seq,
  input logic [sro_pkg::HDL_W-1:0]   out_handle,
  input logic [sro_pkg::MISS_W-1:0]  out_missing_count,
  input logic [CW-1:0]               out_occupancy
);
  import sro_pkg::*;

  // A stalled result holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_seq)
      && $stable(out_handle) && $stable(out_missing_count) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // Only a successful read carries packet fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_READ) |->
      (out_seq == '0) && (out_handle == '0) && (out_missing_count == '0))
    else $error("non-read result carries packet fields");

  // An empty read leaves the buffer empty.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> (out_occupancy == '0))
    else $error("empty read with nonzero occupancy");

  // A full drop is reported only at full occupancy.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> (out_occupancy == CW'(DEPTH)))
    else $error("full drop below full occupancy");

  // After an accepted item the block drops in_ready in the next cycle, while it commits it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted during commit cycle");

endmodule

bind sequence_reorder_buffer_top sro_checker #(.DEPTH(DEPTH)) u_sro_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_seq           (out_seq),
  .out_handle        (out_handle),
  .out_missing_count (out_missing_count),
  .out_occupancy     (out_occupancy)
);
